/* sv/mtrrs_pkg.sv */
package mtrrs_pkg;

   // default column-sum memory depth
   localparam int MAX_COLS_DEFAULT = 1024;

   // field widths
   localparam int ValueW   = 16;
   localparam int SumW     = 32;
   localparam int BestW    = 31;
   localparam int ColsW    = 11;
   localparam int RowsW    = 17;
   localparam int RowCntW  = 16;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 17;

   // largest row count that the row counter covers
   localparam int RowsMax = 65536;

   // register reset values
   localparam logic [ColsW-1:0] COLUMNS_RESET = 11'd1024;
   localparam logic [RowsW-1:0] ROWS_RESET    = 17'd1024;

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   // control carried with an item from the input register to the sum stage
   typedef struct packed {
      logic signed [ValueW-1:0] value;
      logic                     first_row;
      logic                     end_row;
      logic                     end_matrix;
   } s1_ctrl_type;

   // signed add that saturates at the 32-bit limits
   function automatic logic signed [SumW-1:0] sat_add(
      input logic signed [SumW-1:0] a,
      input logic signed [SumW-1:0] b
   );
      logic signed [SumW:0] s;
      logic signed [SumW-1:0] r;
      s = {a[SumW-1], a} + {b[SumW-1], b};
      if (s[SumW] != s[SumW-1]) begin
         r = s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         r = s[SumW-1:0];
      end
      return r;
   endfunction

endpackage

/* sv/mtrrs_ifs.sv */
// matrix element channel
interface mtrrs_req_if
   import mtrrs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [ValueW-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// per-row result channel
interface mtrrs_rsp_if
   import mtrrs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [BestW-1:0] row_best;
   logic [BestW-1:0] overall_best;
   logic             last;

   modport source (output valid, output row_best, output overall_best, output last, input ready);
   modport sink   (input valid, input row_best, input overall_best, input last, output ready);
endinterface

/* sv/max_top_right_rectangle_sum_core.sv */
// result path: the last element of a row is registered in the sum stage, then its result in the output register
// throughput: one element per cycle unless a row result is blocked at the output, set by the
//   column-sum memory read-modify-write: read in the input stage, written in the sum stage, with forwarding
// reset: counters, running sums and valid flags clear, columns and rows return to 1024;
//   the column-sum memory is not cleared, the first row of each matrix loads it
module max_top_right_rectangle_sum_core
   import mtrrs_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   mtrrs_req_if.sink           req,
   mtrrs_rsp_if.source         rsp,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CmpW = 18;

   // configuration registers
   logic [ColsW-1:0]   columns_ff;
   logic [RowsW-1:0]   rows_ff;

   // input stage
   logic [ColW-1:0]    col_cnt_ff, col_cnt_in;
   logic [RowCntW-1:0] row_cnt_ff, row_cnt_in;
   logic [CmpW-1:0]    eff_cols, eff_rows, col_next, row_next;
   logic               end_row, end_matrix, accept, fwd_hit;

   // sum stage
   logic               s1_v_ff, s1_v_in, s1_fire;
   s1_ctrl_type        s1_ff;
   logic [ColW-1:0]    s1_addr_ff;
   logic               fwd_ff;
   logic [SumW-1:0]    fwd_data_ff;
   logic [SumW-1:0]    rd_ff;
   logic [SumW-1:0]    mem [MAX_COLS];
   logic signed [SumW-1:0] base, cs, run_sum;
   logic [BestW-1:0]   run_clamp, new_best;
   logic [BestW-1:0]   row_run_ff, row_run_in, best_ff, best_in;

   // output register
   logic               out_v_ff, out_v_in, out_load;
   logic [BestW-1:0]   out_row_ff, out_best_ff;
   logic               out_last_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMNS: columns_ff <= csr_wdata[ColsW-1:0];
            CSR_ROWS:    rows_ff    <= csr_wdata[RowsW-1:0];
            default:     ;
         endcase
      end
   end

   // effective row length and matrix height
   always_comb begin
      eff_cols = CmpW'(columns_ff);
      if (eff_cols == '0) begin
         eff_cols = CmpW'(1);
      end else if (eff_cols > CmpW'(MAX_COLS)) begin
         eff_cols = CmpW'(MAX_COLS);
      end
      eff_rows = CmpW'(rows_ff);
      if (eff_rows == '0) begin
         eff_rows = CmpW'(1);
      end else if (eff_rows > CmpW'(RowsMax)) begin
         eff_rows = CmpW'(RowsMax);
      end
   end

   // position of the incoming item within the matrix
   assign col_next   = CmpW'(col_cnt_ff) + CmpW'(1);
   assign row_next   = CmpW'(row_cnt_ff) + CmpW'(1);
   assign end_row    = col_next >= eff_cols;
   assign end_matrix = end_row && (row_next >= eff_rows);

   // handshake: the sum stage drains whenever its result has a place to go
   assign s1_fire   = s1_v_ff && (!s1_ff.end_row || !out_v_ff || rsp.ready);
   assign req.ready = !s1_v_ff || s1_fire;
   assign accept    = req.valid && req.ready;
   assign fwd_hit   = s1_fire && (s1_addr_ff == col_cnt_ff);

   // counter next values
   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (end_row) begin
            col_cnt_in = '0;
            row_cnt_in = end_matrix ? '0 : row_cnt_ff + RowCntW'(1);
         end else begin
            col_cnt_in = col_cnt_ff + ColW'(1);
         end
      end
   end

   assign s1_v_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_v_ff);

   // column sum and the clamped chain
   always_comb begin
      base      = fwd_ff ? fwd_data_ff : rd_ff;
      cs        = s1_ff.first_row ? SumW'(s1_ff.value) : sat_add(base, SumW'(s1_ff.value));
      run_sum   = sat_add(cs, {1'b0, row_run_ff});
      run_clamp = run_sum[SumW-1] ? '0 : run_sum[BestW-1:0];
      new_best  = (run_clamp > best_ff) ? run_clamp : best_ff;
   end

   // running state of the row and the matrix
   always_comb begin
      row_run_in = row_run_ff;
      best_in    = best_ff;
      if (s1_fire) begin
         row_run_in = s1_ff.end_row ? '0 : run_clamp;
         if (s1_ff.end_row) begin
            best_in = s1_ff.end_matrix ? '0 : new_best;
         end
      end
   end

   // output register
   assign out_load = s1_fire && s1_ff.end_row;
   assign out_v_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_v_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         s1_v_ff    <= 1'b0;
         row_run_ff <= '0;
         best_ff    <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         s1_v_ff    <= s1_v_in;
         row_run_ff <= row_run_in;
         best_ff    <= best_in;
         out_v_ff   <= out_v_in;
      end
   end

   // item payload into the sum stage, with the forwarded column sum
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.value      <= req.value;
         s1_ff.first_row  <= (row_cnt_ff == '0);
         s1_ff.end_row    <= end_row;
         s1_ff.end_matrix <= end_matrix;
         s1_addr_ff       <= col_cnt_ff;
         fwd_ff           <= fwd_hit;
         fwd_data_ff      <= cs;
      end
   end

   // column-sum memory: read in the input stage, written back from the sum stage
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[col_cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         mem[s1_addr_ff] <= cs;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_row_ff  <= run_clamp;
         out_best_ff <= new_best;
         out_last_ff <= s1_ff.end_matrix;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.row_best     = out_row_ff;
   assign rsp.overall_best = out_best_ff;
   assign rsp.last         = out_last_ff;

`ifndef NO_ASSERTIONS
   // a blocked row end holds back the input
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_ff.end_row && out_v_ff && !rsp.ready) |-> !req.ready)
      else $error("input accepted while a row result is blocked");

   // the chain restarts at every row end
   a_row_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_ff.end_row) |=> (row_run_ff == '0))
      else $error("row chain not cleared at row end");

   // the running maximum restarts after the final row
   a_best_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_ff.end_matrix) |=> (best_ff == '0))
      else $error("best value not cleared at matrix end");

   // a result never reports a maximum below its own row
   a_best_covers_row: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_best_ff >= out_row_ff))
      else $error("overall best below row best");
`endif

endmodule
